@@ src/lds_pkg.sv @@
// Shared constants, types and control structs of the LOOK disk scheduler.
package lds_pkg;

   localparam int MAX_REQUESTS  = 32;
   localparam int POS_BITS      = 16;
   localparam int IDX_BITS      = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_BITS      = $clog2(MAX_REQUESTS + 1);
   localparam int TOT_BITS      = POS_BITS + 1;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   typedef logic [POS_BITS-1:0] pos_type;
   typedef logic [CNT_BITS-1:0] cnt_type;
   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [TOT_BITS-1:0] tot_type;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_HEAD_START = 2'd0,
      CSR_SWEEP_UP   = 2'd1
   } csr_index_type;

   // Per-cell insertion control from the top level
   typedef struct packed {
      logic ins_en;
      logic occupied;
      logic at_tail;
   } cell_ctl_type;

endpackage

@@ src/look_disk_scheduler.sv @@
// Top level of the LOOK disk scheduler: request chain, sequencer and result register.
// Requests enter one per cycle while req_ready is high and are sorted on the
// fly into a chain of MAX_REQUESTS cells; a request that finds the chain full
// is dropped and the batch is flagged with overflow. Accepting the request
// marked last closes the batch: the FIND state locates the head within the
// sorted chain, then the schedule leaves at one move per cycle while
// rsp_ready is high, the head's own zero move first, so a batch of n stored
// requests yields n+1 transactions. No request is taken from the last
// request until the final move of the batch is in the output register.
// head_start and sweep_up are used when the batch is served.
module look_disk_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [lds_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [lds_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lds_pkg::pos_type                    req_request_pos,
   input  logic                                req_last_request,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lds_pkg::pos_type                    rsp_from_pos,
   output lds_pkg::pos_type                    rsp_to_pos,
   output lds_pkg::pos_type                    rsp_movement,
   output lds_pkg::tot_type                    rsp_total_movement,
   output logic                                rsp_overflow,
   output logic                                rsp_last_move
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIND,
      ST_HEAD,
      ST_SERVE
   } state_type;

   // Configuration registers
   lds_pkg::pos_type head_ff;
   logic             sweep_ff;

   // Sequencer state
   state_type        state_ff, state_in;
   lds_pkg::cnt_type count_ff, count_in;
   logic             dropped_ff, dropped_in;
   lds_pkg::cnt_type p_ff, p_in;
   lds_pkg::cnt_type up_ptr_ff, up_ptr_in;
   lds_pkg::cnt_type dn_ptr_ff, dn_ptr_in;
   lds_pkg::pos_type cur_ff, cur_in;
   lds_pkg::tot_type total_ff, total_in;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   lds_pkg::pos_type from_ff, from_in;
   lds_pkg::pos_type to_ff, to_in;
   lds_pkg::pos_type move_ff, move_in;
   lds_pkg::tot_type tot_ff, tot_in;
   logic             ovf_ff, ovf_in;
   logic             lastm_ff, lastm_in;

   // Chain wiring
   lds_pkg::pos_type     cell_val   [lds_pkg::MAX_REQUESTS];
   logic                 cell_gt    [lds_pkg::MAX_REQUESTS];
   logic                 cell_below [lds_pkg::MAX_REQUESTS];
   lds_pkg::cell_ctl_type cell_ctl  [lds_pkg::MAX_REQUESTS];

   logic             ins_en;
   logic             not_full;
   lds_pkg::cnt_type p_enc;
   logic             load;
   logic             take_up;
   logic             serve_last;
   lds_pkg::cnt_type dn_ptr_m1;
   lds_pkg::idx_type rd_idx;
   lds_pkg::pos_type rd_val;
   lds_pkg::pos_type diff;
   lds_pkg::tot_type sum;

   // Configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         sweep_ff <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index)
            lds_pkg::CSR_HEAD_START: head_ff  <= csr_wdata[lds_pkg::POS_BITS-1:0];
            lds_pkg::CSR_SWEEP_UP:   sweep_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign not_full  = (count_ff != lds_pkg::CNT_BITS'(lds_pkg::MAX_REQUESTS));
   assign ins_en    = req_valid && req_ready && not_full;

   // Build the chain of sorting cells
   for (genvar i = 0; i < lds_pkg::MAX_REQUESTS; i++) begin : g_cell
      assign cell_ctl[i].ins_en   = ins_en;
      assign cell_ctl[i].occupied = (lds_pkg::CNT_BITS'(i) < count_ff);
      assign cell_ctl[i].at_tail  = (lds_pkg::CNT_BITS'(i) == count_ff);
      if (i == 0) begin : g_first
         lds_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[i]),
            .ins_pos    (req_request_pos),
            .head_pos   (head_ff),
            .prev_val   (req_request_pos),
            .prev_gt    (1'b0),
            .val        (cell_val[i]),
            .gt         (cell_gt[i]),
            .below_head (cell_below[i])
         );
      end else begin : g_rest
         lds_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[i]),
            .ins_pos    (req_request_pos),
            .head_pos   (head_ff),
            .prev_val   (cell_val[i-1]),
            .prev_gt    (cell_gt[i-1]),
            .val        (cell_val[i]),
            .gt         (cell_gt[i]),
            .below_head (cell_below[i])
         );
      end
   end

   // Encode the below-head thermometer into the head's insertion point
   always_comb begin
      p_enc = '0;
      for (int i = 0; i < lds_pkg::MAX_REQUESTS; i++) begin
         if (cell_below[i] &&
             ((i == lds_pkg::MAX_REQUESTS - 1) ||
              !cell_below[(i + 1) % lds_pkg::MAX_REQUESTS])) begin
            p_enc = p_enc | lds_pkg::CNT_BITS'(i + 1);
         end
      end
   end

   // Pick the next cylinder: upward pointer or downward pointer
   assign take_up    = sweep_ff ? (up_ptr_ff != count_ff) : (dn_ptr_ff == '0);
   assign dn_ptr_m1  = dn_ptr_ff - lds_pkg::CNT_BITS'(1);
   assign rd_idx     = take_up ? up_ptr_ff[lds_pkg::IDX_BITS-1:0]
                               : dn_ptr_m1[lds_pkg::IDX_BITS-1:0];
   assign rd_val     = cell_val[rd_idx];
   assign serve_last = take_up
      ? ((up_ptr_ff + lds_pkg::CNT_BITS'(1) == count_ff) && (dn_ptr_ff == '0))
      : ((dn_ptr_ff == lds_pkg::CNT_BITS'(1)) && (up_ptr_ff == count_ff));
   assign diff       = (cur_ff > rd_val) ? (cur_ff - rd_val) : (rd_val - cur_ff);
   assign sum        = total_ff + lds_pkg::TOT_BITS'(diff);
   assign load       = !rsp_valid_ff || rsp_ready;

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      p_in         = p_ff;
      up_ptr_in    = up_ptr_ff;
      dn_ptr_in    = dn_ptr_ff;
      cur_in       = cur_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      from_in      = from_ff;
      to_in        = to_ff;
      move_in      = move_ff;
      tot_in       = tot_ff;
      ovf_in       = ovf_ff;
      lastm_in     = lastm_ff;

      // Drop the result once taken
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (not_full) begin
                  count_in = count_ff + lds_pkg::CNT_BITS'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last_request) begin
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            p_in     = p_enc;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               from_in      = head_ff;
               to_in        = head_ff;
               move_in      = '0;
               tot_in       = '0;
               ovf_in       = dropped_ff;
               lastm_in     = (count_ff == '0);
               cur_in       = head_ff;
               total_in     = '0;
               up_ptr_in    = p_ff;
               dn_ptr_in    = p_ff;
               if (count_ff == '0) begin
                  state_in   = ST_IDLE;
                  dropped_in = 1'b0;
               end else begin
                  state_in = ST_SERVE;
               end
            end
         end
         ST_SERVE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               from_in      = cur_ff;
               to_in        = rd_val;
               move_in      = diff;
               tot_in       = sum;
               ovf_in       = dropped_ff;
               lastm_in     = serve_last;
               cur_in       = rd_val;
               total_in     = sum;
               if (take_up) begin
                  up_ptr_in = up_ptr_ff + lds_pkg::CNT_BITS'(1);
               end else begin
                  dn_ptr_in = dn_ptr_m1;
               end
               // Close the batch and clear the store for the next one
               if (serve_last) begin
                  state_in   = ST_IDLE;
                  count_in   = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      up_ptr_ff <= up_ptr_in;
      dn_ptr_ff <= dn_ptr_in;
      cur_ff    <= cur_in;
      total_ff  <= total_in;
      from_ff   <= from_in;
      to_ff     <= to_in;
      move_ff   <= move_in;
      tot_ff    <= tot_in;
      ovf_ff    <= ovf_in;
      lastm_ff  <= lastm_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_from_pos       = from_ff;
   assign rsp_to_pos         = to_ff;
   assign rsp_movement       = move_ff;
   assign rsp_total_movement = tot_ff;
   assign rsp_overflow       = ovf_ff;
   assign rsp_last_move      = lastm_ff;

   // Occupied cells stay in ascending order
   for (genvar i = 1; i < lds_pkg::MAX_REQUESTS; i++) begin : g_chk
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         (lds_pkg::CNT_BITS'(i) < count_ff) |-> (cell_val[i-1] <= cell_val[i]))
         else $error("request chain out of order");
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lds_pkg::CNT_BITS'(lds_pkg::MAX_REQUESTS))
      else $error("request count beyond capacity");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (dropped_ff && (state_ff == ST_IDLE)) |->
         (count_ff == lds_pkg::CNT_BITS'(lds_pkg::MAX_REQUESTS)))
      else $error("request dropped while store not full");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SERVE) |->
         ((up_ptr_ff <= count_ff) && (dn_ptr_ff <= p_ff) && (up_ptr_ff >= p_ff)))
      else $error("service pointers out of range");

endmodule

@@ src/lds_cell.sv @@
// One cell of the sorted request chain: holds one cylinder and shifts on insert.
module lds_cell (
   input  logic                  clock,
   input  lds_pkg::cell_ctl_type ctl,
   input  lds_pkg::pos_type      ins_pos,
   input  lds_pkg::pos_type      head_pos,
   input  lds_pkg::pos_type      prev_val,
   input  logic                  prev_gt,
   output lds_pkg::pos_type      val,
   output logic                  gt,
   output logic                  below_head
);

   lds_pkg::pos_type val_ff;
   lds_pkg::pos_type val_in;

   // Compare the held cylinder against the new request and the head
   assign gt         = ctl.occupied && (val_ff > ins_pos);
   assign below_head = ctl.occupied && (val_ff < head_pos);
   assign val        = val_ff;

   // Take the neighbor's value when it moves up, else the new request
   always_comb begin
      val_in = val_ff;
      if (ctl.ins_en && (gt || ctl.at_tail)) begin
         val_in = prev_gt ? prev_val : ins_pos;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the LOOK disk scheduler: random batches against a schedule predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Register indexes that the block does not decode
   localparam logic [lds_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [lds_pkg::CSR_IDX_BITS-1:0] CSR_SPARE_HI = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int TARGET_REQUESTS = 470;
   localparam int POS_MAX = (1 << lds_pkg::POS_BITS) - 1;

   typedef struct packed {
      lds_pkg::pos_type from_pos;
      lds_pkg::pos_type to_pos;
      lds_pkg::pos_type movement;
      lds_pkg::tot_type total_movement;
      logic             overflow;
      logic             last_move;
   } head_move_type;

   // Sorted request store and the LOOK order it yields on the closing request
   class look_schedule_board;
      lds_pkg::pos_type sorted_q[$];
      bit               dropped;
      lds_pkg::pos_type head_pos;
      bit               sweep_up;
      head_move_type    moves_q[$];
      int unsigned      errors;
      lds_pkg::pos_type cur_pos;
      int unsigned      run_total;

      function new();
         dropped  = 1'b0;
         head_pos = '0;
         sweep_up = 1'b1;
         errors   = 0;
      endfunction

      function int unsigned outstanding();
         return moves_q.size();
      endfunction

      function void add_move(lds_pkg::pos_type to, bit last);
         head_move_type    m;
         lds_pkg::pos_type move_len;
         move_len = (cur_pos > to) ? cur_pos - to : to - cur_pos;
         run_total += move_len;
         m.from_pos       = cur_pos;
         m.to_pos         = to;
         m.movement       = move_len;
         m.total_movement = lds_pkg::tot_type'(run_total);
         m.overflow       = dropped;
         m.last_move      = last;
         moves_q.push_back(m);
         cur_pos = to;
      endfunction

      function void note_request(lds_pkg::pos_type pos, bit last);
         int n;
         int p;
         int k;
         int i;
         // insert in ascending order, or drop and flag when the store is full
         if (sorted_q.size() < lds_pkg::MAX_REQUESTS) begin
            i = sorted_q.size();
            while (i > 0 && sorted_q[i-1] > pos) i--;
            sorted_q.insert(i, pos);
         end else begin
            dropped = 1'b1;
         end
         if (!last) return;

         n = sorted_q.size();
         p = 0;
         while (p < n && sorted_q[p] < head_pos) p++;
         cur_pos   = head_pos;
         run_total = 0;
         add_move(head_pos, n == 0);
         k = 1;
         if (sweep_up) begin
            for (i = p; i < n; i++) begin
               add_move(sorted_q[i], k == n);
               k++;
            end
            for (i = p; i > 0; i--) begin
               add_move(sorted_q[i-1], k == n);
               k++;
            end
         end else begin
            for (i = p; i > 0; i--) begin
               add_move(sorted_q[i-1], k == n);
               k++;
            end
            for (i = p; i < n; i++) begin
               add_move(sorted_q[i], k == n);
               k++;
            end
         end
         sorted_q.delete();
         dropped = 1'b0;
      endfunction

      function void check_field(string name, int unsigned exp_val, int unsigned got_val);
         if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
         end
      endfunction

      function void check_move(head_move_type got);
         head_move_type exp_m;
         if (moves_q.size() == 0) begin
            $error("unexpected move transaction: from %0d to %0d", got.from_pos, got.to_pos);
            errors++;
            return;
         end
         exp_m = moves_q.pop_front();
         check_field("from_pos", exp_m.from_pos, got.from_pos);
         check_field("to_pos", exp_m.to_pos, got.to_pos);
         check_field("movement", exp_m.movement, got.movement);
         check_field("total_movement", exp_m.total_movement, got.total_movement);
         check_field("overflow", exp_m.overflow, got.overflow);
         check_field("last_move", exp_m.last_move, got.last_move);
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_write_en = 1'b0;
   logic [lds_pkg::CSR_IDX_BITS-1:0]    csr_index = lds_pkg::CSR_HEAD_START;
   logic [lds_pkg::CSR_DATA_BITS-1:0]   csr_wdata = '0;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   lds_pkg::pos_type                    req_request_pos = '0;
   logic                                req_last_request = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   lds_pkg::pos_type                    rsp_from_pos;
   lds_pkg::pos_type                    rsp_to_pos;
   lds_pkg::pos_type                    rsp_movement;
   lds_pkg::tot_type                    rsp_total_movement;
   logic                                rsp_overflow;
   logic                                rsp_last_move;

   look_schedule_board board = new();
   bit                 steady = 1'b0;
   int unsigned        request_total = 0;

   look_disk_scheduler dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_request_pos    (req_request_pos),
      .req_last_request   (req_last_request),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_from_pos       (rsp_from_pos),
      .rsp_to_pos         (rsp_to_pos),
      .rsp_movement       (rsp_movement),
      .rsp_total_movement (rsp_total_movement),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_move      (rsp_last_move)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned draw_gap();
      return steady ? 0 : $urandom_range(0, 14);
   endfunction

   // Check every move transaction against the oldest predicted move
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_move({rsp_from_pos, rsp_to_pos, rsp_movement, rsp_total_movement,
                           rsp_overflow, rsp_last_move});
   end

   // Stall the result side for a random number of cycles before each transaction
   initial begin : rsp_side
      int unsigned stall;
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
      end
   end

   // Offer one request; valid stays high into the next call when no gap is drawn
   task automatic send_request(lds_pkg::pos_type pos, bit last);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_request_pos  <= pos;
      req_last_request <= last;
      do @(posedge clock); while (!req_ready);
      board.note_request(pos, last);
      request_total++;
   endtask

   task automatic run_batch(lds_pkg::pos_type list[$]);
      foreach (list[i]) send_request(list[i], i == list.size() - 1);
   endtask

   // Drop valid, wait for the schedule to drain, then let the block settle
   task automatic wait_schedule_done();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers, and optionally an undecoded index that must be ignored
   task automatic write_config(lds_pkg::pos_type head, bit up, bit spare);
      logic [lds_pkg::CSR_DATA_BITS-1:0] sweep_word;
      sweep_word    = lds_pkg::CSR_DATA_BITS'($urandom);
      sweep_word[0] = up;
      csr_write_en <= 1'b1;
      csr_index    <= lds_pkg::CSR_HEAD_START;
      csr_wdata    <= head;
      @(posedge clock);
      csr_index    <= lds_pkg::CSR_SWEEP_UP;
      csr_wdata    <= sweep_word;
      @(posedge clock);
      if (spare) begin
         csr_index <= $urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO;
         csr_wdata <= lds_pkg::CSR_DATA_BITS'($urandom);
         @(posedge clock);
      end
      csr_write_en  <= 1'b0;
      board.head_pos = head;
      board.sweep_up = up;
   endtask

   function automatic lds_pkg::pos_type pick_pos(lds_pkg::pos_type head,
                                                 lds_pkg::pos_type prev);
      int near;
      case ($urandom_range(0, 9))
         0: return head;
         1: return prev;
         2, 3: begin
            near = int'(head) + $urandom_range(0, 40) - 20;
            if (near < 0) near = 0;
            if (near > POS_MAX) near = POS_MAX;
            return lds_pkg::pos_type'(near);
         end
         4: return $urandom_range(0, 1) ? lds_pkg::pos_type'(POS_MAX) : lds_pkg::pos_type'(0);
         default: return lds_pkg::pos_type'($urandom_range(0, POS_MAX));
      endcase
   endfunction

   initial begin : stimulus
      lds_pkg::pos_type list[$];
      lds_pkg::pos_type head;
      lds_pkg::pos_type prev;
      int unsigned      size;
      int unsigned      batches;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: head at 0 sweeping up, requests equal to the head
      list = '{16'hFFFF, 16'h0000, 16'h0000};
      run_batch(list);
      wait_schedule_done();
      // Head at the top sweeping down, requests equal to the head
      write_config(16'hFFFF, 1'b0, 1'b1);
      list = '{16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF};
      run_batch(list);
      wait_schedule_done();
      write_config(16'hFFFF, 1'b1, 1'b0);
      list = '{16'd100, 16'hFFFF};
      run_batch(list);
      wait_schedule_done();
      // Single request on the head
      write_config(16'd1000, 1'b1, 1'b0);
      list = '{16'd1000};
      run_batch(list);
      wait_schedule_done();
      write_config(16'd1000, 1'b0, 1'b1);
      list = '{16'd999, 16'd1001, 16'd1000, 16'd5, 16'd60000};
      run_batch(list);
      wait_schedule_done();
      // Everything below, then everything above, a downward head
      write_config(16'd40000, 1'b0, 1'b0);
      list = '{16'd10, 16'd20};
      run_batch(list);
      list = '{16'd50000, 16'd41000};
      run_batch(list);
      wait_schedule_done();

      // Random phases: new settings, then a few batches, some overfilling the store
      while (request_total < TARGET_REQUESTS) begin
         case ($urandom_range(0, 5))
            0: head = '0;
            1: head = lds_pkg::pos_type'(POS_MAX);
            default: head = lds_pkg::pos_type'($urandom_range(0, POS_MAX));
         endcase
         write_config(head, $urandom_range(0, 1), $urandom_range(0, 3) == 0);
         batches = $urandom_range(3, 6);
         repeat (batches) begin
            steady = ($urandom_range(0, 4) == 0);
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40)
                                              : $urandom_range(1, 10);
            list.delete();
            prev = lds_pkg::pos_type'($urandom_range(0, POS_MAX));
            repeat (size) begin
               prev = pick_pos(head, prev);
               list.push_back(prev);
            end
            run_batch(list);
         end
         steady = 1'b0;
         wait_schedule_done();
      end

      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("** look_disk_scheduler: PASSED **");
      end else begin
         $display("** look_disk_scheduler: FAILED **");
      end
      $finish;
   end

   // Hard limit on the run
   initial begin : watchdog
      #5ms;
      $display("** look_disk_scheduler: FAILED **");
      $finish;
   end

endmodule

@@ filelist.f @@
src/lds_pkg.sv
src/lds_cell.sv
src/look_disk_scheduler.sv
sim/tb.sv
